>>> rtl/core/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg
// shared types and constants for the combination coefficient block
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int MAX_INDICES = 64;
  localparam int MAX_DIMS    = 4;
  localparam int LEVEL_BITS  = 4;

  localparam int IN_DIMS   = 4;
  localparam int IN_LEVEL_W = 4;
  localparam int COEFF_W   = 6;
  localparam int ENTRY_W   = 6;
  localparam int CFG_W     = 3;
  localparam int CFG_RESET = 4;

  localparam int ADDR_W = $clog2(MAX_INDICES);
  localparam int CNT_W  = $clog2(MAX_INDICES + 1);
  localparam int DIM_W  = $clog2(MAX_DIMS + 1);
  localparam int KEY_W  = MAX_DIMS * LEVEL_BITS;

  typedef logic [LEVEL_BITS-1:0]              level_t;
  typedef level_t [MAX_DIMS-1:0]              key_t;
  typedef logic signed [COEFF_W-1:0]          coeff_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_ENTRY,
    S_GET_ENTRY,
    S_SCAN,
    S_GET_SUCC,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_OUT
  } state_t;

endpackage

>>> rtl/core/combination_coefficients_dimwise.sv
// ----------------------------------------------------------------------------
// combination_coefficients_dimwise
// combination technique coefficients of a set of level multi-indices
// ----------------------------------------------------------------------------
// Multi-indices load one transaction per cycle into an index ram until the
// transaction marked last_index arrives; indices beyond 64 are dropped and
// reported through truncated. The block then runs one pass per active
// dimension: for each entry it reads the entry, scans the index ram one word
// per cycle from entry zero for the successor (level raised by one in that
// dimension) and writes coefficient minus successor coefficient (or the
// coefficient itself, if none) into the other of two ping-pong coefficient
// rams. The single read port of the index ram bounds the pace of a pass.
// Results then leave in load order, each read only after the one before is
// taken, and the input is not ready again until the final coefficient
// transaction is taken. Input is only accepted in the load phase. The user
// must write active_dims only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module combination_coefficients_dimwise
  import ccd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                active_dims_wr_en,
  input  logic [CFG_W-1:0]    active_dims_wr_data,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IN_LEVEL_W-1:0] level_d0,
  input  logic [IN_LEVEL_W-1:0] level_d1,
  input  logic [IN_LEVEL_W-1:0] level_d2,
  input  logic [IN_LEVEL_W-1:0] level_d3,
  input  logic                last_index,
  // output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [COEFF_W-1:0] coefficient,
  output logic [ENTRY_W-1:0]  entry_number,
  output logic                truncated,
  output logic                last_result
);

  // control state
  state_t            state, state_next;
  logic [CFG_W-1:0]  active_dims;
  logic [CNT_W-1:0]  entry_count;
  logic              overflow_flag;
  logic [CNT_W-1:0]  entry_idx;   // entry being updated or emitted
  logic [CNT_W-1:0]  scan_idx;    // candidate successor under compare
  logic [DIM_W-1:0]  pass_dim;    // current pass, also selects the ram bank
  // payload state
  coeff_t            coeff_entry;
  key_t              want_key;

  // ram ports
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_raddr;
  logic [KEY_W-1:0]  tbl_wdata, tbl_rdata;
  logic              c0_we, c1_we;
  logic [ADDR_W-1:0] c_raddr;
  logic [COEFF_W-1:0] c_wdata, c0_rdata, c1_rdata;
  logic              coeff_wr;

  // decode
  logic [DIM_W-1:0]  ndims;
  logic              in_fire, out_fire;
  logic              entry_last, scan_last, pass_last;
  logic              at_max, succ_match;
  coeff_t            coeff_rd, diff_sat;
  key_t              rd_key, key_inc, in_key;
  logic [IN_LEVEL_W-1:0] in_lv [IN_DIMS];
  logic signed [COEFF_W:0] diff;

  ccd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_INDICES)) u_index_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (entry_count[ADDR_W-1:0]),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // two coefficient banks, pass d writes bank d[0] and reads the other
  ccd_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_INDICES)) u_coeff_ram0 (
    .clk   (clk),
    .we    (c0_we),
    .waddr (entry_idx[ADDR_W-1:0]),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c0_rdata)
  );

  ccd_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_INDICES)) u_coeff_ram1 (
    .clk   (clk),
    .we    (c1_we),
    .waddr (entry_idx[ADDR_W-1:0]),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c1_rdata)
  );

  // datapath decode
  always_comb begin
    ndims = (int'(active_dims) > MAX_DIMS) ? DIM_W'(MAX_DIMS) : DIM_W'(active_dims);
    in_fire  = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    entry_last = (entry_idx + CNT_W'(1)) == entry_count;
    scan_last  = (scan_idx + CNT_W'(1)) == entry_count;
    pass_last  = (pass_dim + DIM_W'(1)) == ndims;

    in_lv[0] = level_d0;
    in_lv[1] = level_d1;
    in_lv[2] = level_d2;
    in_lv[3] = level_d3;
    // levels beyond the four input fields load as zero
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (k < IN_DIMS) begin
        in_key[k] = LEVEL_BITS'(in_lv[k % IN_DIMS]);
      end else begin
        in_key[k] = '0;
      end
    end
    tbl_wdata = KEY_W'(in_key);

    rd_key = key_t'(tbl_rdata);
    at_max = 1'b0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (DIM_W'(k) == pass_dim) begin
        key_inc[k] = rd_key[k] + LEVEL_BITS'(1);
        if (rd_key[k] == {LEVEL_BITS{1'b1}}) at_max = 1'b1;
      end else begin
        key_inc[k] = rd_key[k];
      end
    end

    // only active dimensions take part in the match
    succ_match = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if ((k < int'(ndims)) && (rd_key[k] != want_key[k])) succ_match = 1'b0;
    end

    // first pass reads the start value of one
    if (pass_dim == '0) begin
      coeff_rd = COEFF_W'(1);
    end else begin
      coeff_rd = pass_dim[0] ? coeff_t'(c0_rdata) : coeff_t'(c1_rdata);
    end

    diff = {coeff_entry[COEFF_W-1], coeff_entry} - {coeff_rd[COEFF_W-1], coeff_rd};
    if (diff[COEFF_W] != diff[COEFF_W-1]) begin
      diff_sat = diff[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
    end else begin
      diff_sat = diff[COEFF_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_fire && last_index) begin
          state_next = (ndims == '0) ? S_EMIT_RD : S_RD_ENTRY;
        end
      end
      S_RD_ENTRY: state_next = S_GET_ENTRY;
      S_GET_ENTRY: begin
        if (at_max) begin
          state_next = (entry_last && pass_last) ? S_EMIT_RD : S_RD_ENTRY;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (succ_match) begin
          state_next = S_GET_SUCC;
        end else if (scan_last) begin
          state_next = (entry_last && pass_last) ? S_EMIT_RD : S_RD_ENTRY;
        end
      end
      S_GET_SUCC: state_next = (entry_last && pass_last) ? S_EMIT_RD : S_RD_ENTRY;
      S_EMIT_RD:  state_next = S_EMIT_LD;
      S_EMIT_LD:  state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_fire) begin
          state_next = entry_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // ram control and handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    tbl_we    = 1'b0;
    tbl_raddr = entry_idx[ADDR_W-1:0];
    c_raddr   = entry_idx[ADDR_W-1:0];
    coeff_wr  = 1'b0;
    c_wdata   = coeff_entry;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        tbl_we   = in_fire && (int'(entry_count) < MAX_INDICES);
      end
      S_GET_ENTRY: begin
        tbl_raddr = '0;
        coeff_wr  = at_max;
        c_wdata   = coeff_rd;
      end
      S_SCAN: begin
        tbl_raddr = ADDR_W'(scan_idx + CNT_W'(1));
        c_raddr   = scan_idx[ADDR_W-1:0];
        coeff_wr  = !succ_match && scan_last;
      end
      S_GET_SUCC: begin
        coeff_wr = 1'b1;
        c_wdata  = diff_sat;
      end
      S_EMIT_OUT: out_valid = 1'b1;
      default: ;
    endcase
    c0_we = coeff_wr && !pass_dim[0];
    c1_we = coeff_wr && pass_dim[0];
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      active_dims   <= CFG_W'(CFG_RESET);
      entry_count   <= '0;
      overflow_flag <= 1'b0;
      entry_idx     <= '0;
      scan_idx      <= '0;
      pass_dim      <= '0;
    end else begin
      state <= state_next;
      if (active_dims_wr_en) active_dims <= active_dims_wr_data;

      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (int'(entry_count) < MAX_INDICES) begin
              entry_count <= entry_count + CNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            entry_idx <= '0;
            pass_dim  <= '0;
          end
        end
        S_GET_ENTRY: begin
          scan_idx <= '0;
        end
        S_SCAN: begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        S_EMIT_OUT: begin
          if (out_ready) begin
            if (entry_last) begin
              entry_count   <= '0;
              overflow_flag <= 1'b0;
              entry_idx     <= '0;
            end else begin
              entry_idx <= entry_idx + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase

      // step to the next entry once its new coefficient is written
      if (coeff_wr) begin
        if (entry_last) begin
          entry_idx <= '0;
          pass_dim  <= pass_dim + DIM_W'(1);
        end else begin
          entry_idx <= entry_idx + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_GET_ENTRY) begin
      coeff_entry <= coeff_rd;
      want_key    <= key_inc;
    end
    if (state == S_EMIT_LD) begin
      coefficient  <= coeff_rd;
      entry_number <= ENTRY_W'(entry_idx);
      truncated    <= overflow_flag;
      last_result  <= entry_last;
    end
  end

`ifndef SYNTH
  // load and emission phases never overlap
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while a result is offered");

  // the fill count never passes the table depth
  assert property (@(posedge clk) disable iff (rst) int'(entry_count) <= MAX_INDICES)
    else $error("entry count beyond table depth");

  // taking the final coefficient reopens the input for a new set
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> (in_ready && entry_count == '0))
    else $error("set not closed after final coefficient");
`endif

endmodule

>>> rtl/core/ccd_ram.sv
// ----------------------------------------------------------------------------
// ccd_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
